[rtl/core/brdf_pkg.sv]
// Shared types, constants and the row mask function for the row dedup filter.
// Used by brdf_cell and binary_row_dedup_filter_unit; no dependencies.
package brdf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ROW_WIDTH   = 64;
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 7;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(ROW_WIDTH);

    // Query word that walks along the chain of cells
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] row;
        logic              hit;
        logic              stored;
    } query_t;

    function automatic logic [WORD_W-1:0] row_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] eff;
        eff = len;
        if (eff == '0)
        begin
            eff = LEN_W'(1);
        end
        if (eff > LEN_MAX)
        begin
            eff = LEN_MAX;
        end
        // shift by the full width gives zero, so the mask becomes all ones
        return ~({WORD_W{1'b1}} << eff);
    endfunction

endpackage

[rtl/core/brdf_cell.sv]
// One cell of the seen-row chain: one stored row with its valid bit and one query stage.
// Depends on brdf_pkg.
module brdf_cell
    import brdf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   clear,
    input  query_t q_in,
    output query_t q_out
);

    query_t            q_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] entry_reg;
    logic              match;
    logic              take;

    assign match = valid_reg && (entry_reg == q_reg.row);
    // valid cells form a prefix, so the first empty cell a missing row meets is the free slot
    assign take  = q_reg.valid && !q_reg.hit && !q_reg.stored && !valid_reg;

    always_comb
    begin
        q_out        = q_reg;
        q_out.hit    = q_reg.hit || match;
        q_out.stored = q_reg.stored || take;
        valid_next   = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            q_reg     <= q_in;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= q_reg.row;
        end
    end

endmodule

[rtl/core/binary_row_dedup_filter_unit.sv]
// Top level of the binary row dedup filter: mask, query injection, chain of cells, result word.
// Depends on brdf_pkg and brdf_cell.
//
// Each accepted row word walks the chain of TABLE_DEPTH cells, one cell per clock, and is
// compared with the row each cell holds; a new row is written into the first empty cell it
// meets. The result word shows on row_out, is_new and overflow with done high for one cycle;
// busy drops at the edge that raises done, so the next start can be taken at the edge that
// takes the result. A new row is not taken while the last one is still in the chain. The receiver
// cannot stall, so each result must be taken in its cycle.
// A row with first_row high empties the table before it is looked up.
module binary_row_dedup_filter_unit
    import brdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] row_value,
    input  logic              first_row,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    output logic              done,
    output logic [WORD_W-1:0] row_out,
    output logic              is_new,
    output logic              overflow
);

    logic              accept;
    logic              clear;
    logic [LEN_W-1:0]  len_reg;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic [WORD_W-1:0] row_out_reg;
    logic              is_new_reg;
    logic              overflow_reg;
    query_t            inject;
    query_t            link [TABLE_DEPTH+1];

    assign accept = start && !busy_reg;
    assign clear  = accept && first_row;

    always_comb
    begin
        inject.valid  = accept;
        inject.row    = row_value & row_mask(len_reg);
        inject.hit    = 1'b0;
        inject.stored = 1'b0;
    end

    assign link[0] = inject;

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++)
        begin : g_cell
            brdf_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (clear),
                .q_in  (link[k]),
                .q_out (link[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (link[TABLE_DEPTH].valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            busy_reg <= busy_next;
            done_reg <= link[TABLE_DEPTH].valid;
        end
    end

    // hold the result word once it leaves the last cell
    always_ff @(posedge clk)
    begin
        if (link[TABLE_DEPTH].valid)
        begin
            row_out_reg  <= link[TABLE_DEPTH].row;
            is_new_reg   <= !link[TABLE_DEPTH].hit;
            overflow_reg <= !link[TABLE_DEPTH].hit && !link[TABLE_DEPTH].stored;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign row_out  = row_out_reg;
    assign is_new   = is_new_reg;
    assign overflow = overflow_reg;

endmodule

[rtl/core/brdf_checker.sv]
// Port-level checks on the row dedup filter handshake and result flags, bound to the top level.
// Depends on binary_row_dedup_filter_unit.
module brdf_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic is_new,
    input logic overflow
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted word");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result word without a preceding busy period");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result words in consecutive cycles");

    a_overflow_new: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> is_new)
        else $error("overflow flagged on a row already seen");

endmodule

bind binary_row_dedup_filter_unit brdf_checker u_brdf_checker (.*);
